/* src/dfr_pkg.sv */
// Shared types, constants and helper functions for the typed record stream deframer.
// Used by the parser, the field table scanner and the top level.
package dfr_pkg;

  // fixed layout constants
  localparam int LOCAL_TYPES    = 16;
  localparam int TYPE_W         = 4;
  localparam int MAX_FIELDS_DEF = 128;
  localparam int HEADER_LEN_DEF = 14;
  localparam int QUEUE_DEPTH    = 2;

  // parser phases, one-hot
  typedef enum logic [13:0] {
    PH_HDR      = 14'b00000000000001,
    PH_REC      = 14'b00000000000010,
    PH_DEFFIX   = 14'b00000000000100,
    PH_FIELD    = 14'b00000000001000,
    PH_DEVCNT   = 14'b00000000010000,
    PH_DEVDEF   = 14'b00000000100000,
    PH_DATA     = 14'b00000001000000,
    PH_CRC      = 14'b00000010000000,
    PH_ERR_SIG  = 14'b00000100000000,
    PH_ERR_HCRC = 14'b00001000000000,
    PH_ERR_UNDEF= 14'b00010000000000,
    PH_ERR_MANY = 14'b00100000000000,
    PH_ERR_CRC  = 14'b01000000000000,
    PH_PASSED   = 14'b10000000000000
  } phase_e;

  // byte class codes
  typedef enum logic [3:0] {
    CLS_HDR       = 4'd0,
    CLS_REC_HDR   = 4'd1,
    CLS_DEF_FIXED = 4'd2,
    CLS_FIELD_DEF = 4'd3,
    CLS_DEV_COUNT = 4'd4,
    CLS_DEV_DEF   = 4'd5,
    CLS_DATA      = 4'd6,
    CLS_DEV_DATA  = 4'd7,
    CLS_CRC       = 4'd8,
    CLS_IGNORED   = 4'd9
  } class_e;

  // status codes
  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_BAD_SIG  = 3'd1,
    ST_HDR_CRC  = 3'd2,
    ST_UNDEF    = 3'd3,
    ST_TOO_MANY = 3'd4,
    ST_FILE_CRC = 3'd5,
    ST_PASSED   = 3'd6
  } status_e;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } item_t;

  // result transaction
  typedef struct packed {
    class_e     byte_class;
    logic [3:0] local_type;
    logic [6:0] field_index;
    logic [7:0] field_base_type;
    logic       field_last;
    logic       record_last;
    logic       compressed_time;
    logic [4:0] time_offset;
    status_e    status;
  } result_t;

  // scanner status toward the parser
  typedef struct packed {
    logic done;
    logic last;
  } scan_rsp_t;

  // one byte of the reflected crc-16, polynomial 0xA001
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  // file signature bytes
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h2E;
      2'd1: r = 8'h46;
      2'd2: r = 8'h49;
      default: r = 8'h54;
    endcase
    return r;
  endfunction

  // local type of a record header, compressed timestamp bit first
  function automatic logic [TYPE_W-1:0] rec_type(input logic [7:0] h);
    return h[7] ? {2'b00, h[6:5]} : h[3:0];
  endfunction

endpackage

/* src/typed_record_stream_deframer_unit.sv */
// Top level of the typed record stream deframer: input queue, parser, field table
// scanner and result queue. Depends on dfr_pkg, dfr_fifo, dfr_scan and dfr_parser.
//
//   channel   handshake          payload
//   input     push / full        data_byte_i, file_start_i
//   result    empty / pop        byte_class_o .. status_o
//
// One byte per cycle in definitions, file header, crc and inside data fields, while the
// result queue has room. A data record header waits at the queue head until the scan
// of the field table for its first sized field is done; a header of an undefined type
// does not wait. A field change inside a data record stalls until the background scan
// of the field table is done; the scan overlaps the field.
// Reset clears the queues and parser state; the field table needs no clearing.
// Either side may stall on its own; the queues absorb the difference.
module typed_record_stream_deframer_unit #(
  parameter int MAX_FIELDS = dfr_pkg::MAX_FIELDS_DEF,
  parameter int HEADER_LEN = dfr_pkg::HEADER_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       file_start_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] byte_class_o,
  output logic [3:0] local_type_o,
  output logic [6:0] field_index_o,
  output logic [7:0] field_base_type_o,
  output logic       field_last_o,
  output logic       record_last_o,
  output logic       compressed_time_o,
  output logic [4:0] time_offset_o,
  output logic [2:0] status_o
);
  import dfr_pkg::*;

  localparam int FIDX_W = $clog2(MAX_FIELDS + 1);

  item_t             in_wdata, in_head;
  logic              in_empty, item_pop;
  result_t           res_wdata, res_head;
  logic              res_push, res_full;
  logic              sc_start, tw_we;
  logic [FIDX_W-1:0] sc_from, sc_total, sc_idx, tw_field;
  logic [TYPE_W-1:0] sc_type, tw_type;
  logic [15:0]       sc_entry, tw_data;
  scan_rsp_t         sc_rsp;

  assign in_wdata.data_byte  = data_byte_i;
  assign in_wdata.file_start = file_start_i;

  // input queue
  dfr_fifo #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk_i, .rst_ni,
    .wr_i(push), .wdata_i(in_wdata), .full_o(full),
    .rd_i(item_pop), .rdata_o(in_head), .empty_o(in_empty)
  );

  // parser
  dfr_parser #(.MAX_FIELDS(MAX_FIELDS), .HEADER_LEN(HEADER_LEN)) u_parser (
    .clk_i, .rst_ni,
    .in_item_i(in_head), .in_valid_i(~in_empty), .in_pop_o(item_pop),
    .out_full_i(res_full), .out_push_o(res_push), .out_item_o(res_wdata),
    .sc_start_o(sc_start), .sc_from_o(sc_from), .sc_type_o(sc_type),
    .sc_total_o(sc_total), .sc_rsp_i(sc_rsp), .sc_idx_i(sc_idx), .sc_entry_i(sc_entry),
    .tw_we_o(tw_we), .tw_type_o(tw_type), .tw_field_o(tw_field), .tw_data_o(tw_data)
  );

  // field table and scanner
  dfr_scan #(.MAX_FIELDS(MAX_FIELDS)) u_scan (
    .clk_i, .rst_ni,
    .start_i(sc_start), .from_i(sc_from), .type_i(sc_type), .total_i(sc_total),
    .we_i(tw_we), .wtype_i(tw_type), .wfield_i(tw_field), .wdata_i(tw_data),
    .rsp_o(sc_rsp), .idx_o(sc_idx), .entry_o(sc_entry)
  );

  // result queue
  dfr_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i, .rst_ni,
    .wr_i(res_push), .wdata_i(res_wdata), .full_o(res_full),
    .rd_i(pop), .rdata_o(res_head), .empty_o(empty)
  );

  assign byte_class_o      = res_head.byte_class;
  assign local_type_o      = res_head.local_type;
  assign field_index_o     = res_head.field_index;
  assign field_base_type_o = res_head.field_base_type;
  assign field_last_o      = res_head.field_last;
  assign record_last_o     = res_head.record_last;
  assign compressed_time_o = res_head.compressed_time;
  assign time_offset_o     = res_head.time_offset;
  assign status_o          = res_head.status;

  // every consumed byte yields exactly one result
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop == res_push) else $error("byte consumed without result");

  // the parser never writes into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result queue overflow");

  // field end marks only appear on field bytes
  a_field_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && field_last_o) |-> (byte_class_o == CLS_FIELD_DEF ||
      byte_class_o == CLS_DEV_DEF || byte_class_o == CLS_DATA ||
      byte_class_o == CLS_DEV_DATA)) else $error("field end on non-field byte");

  // a passed file is only reported on crc or ignored bytes
  a_passed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_PASSED) |-> (byte_class_o == CLS_CRC ||
      byte_class_o == CLS_IGNORED)) else $error("pass status on data byte");
endmodule

/* src/dfr_fifo.sv */
// Small synchronous queue with full and empty flags.
// Used for the input and result queues of the deframer; depth is a power of two.
module dfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dfr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i & ~full_o;
  assign rd_en   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) wptr_q <= wptr_q + 1'b1;
      if (rd_en) rptr_q <= rptr_q + 1'b1;
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

/* src/dfr_scan.sv */
// Field table memory and next-field scanner of the deframer.
// Finds the next field with nonzero size for a local type; depends on dfr_pkg.
module dfr_scan #(
  parameter int MAX_FIELDS = dfr_pkg::MAX_FIELDS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [$clog2(MAX_FIELDS+1)-1:0]        from_i,
  input  logic [dfr_pkg::TYPE_W-1:0]             type_i,
  input  logic [$clog2(MAX_FIELDS+1)-1:0]        total_i,
  input  logic                                   we_i,
  input  logic [dfr_pkg::TYPE_W-1:0]             wtype_i,
  input  logic [$clog2(MAX_FIELDS+1)-1:0]        wfield_i,
  input  logic [15:0]                            wdata_i,
  output dfr_pkg::scan_rsp_t                     rsp_o,
  output logic [$clog2(MAX_FIELDS+1)-1:0]        idx_o,
  output logic [15:0]                            entry_o
);
  import dfr_pkg::*;

  localparam int FIDX_W = $clog2(MAX_FIELDS + 1);
  localparam int FI_W   = $clog2(MAX_FIELDS);
  localparam int AW     = TYPE_W + FI_W;

  typedef enum logic [3:0] {
    SC_IDLE  = 4'b0001,
    SC_ISSUE = 4'b0010,
    SC_WAIT  = 4'b0100,
    SC_DONE  = 4'b1000
  } scan_state_e;

  logic [15:0]       mem_q [2**AW];
  logic [15:0]       rdata_q;
  scan_state_e       st_q, st_d;
  logic [FIDX_W-1:0] ptr_q, ptr_d, total_q, total_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic              last_q, last_d;
  logic [15:0]       ent_q, ent_d;
  logic              rd_en;

  assign rd_en = (st_q == SC_ISSUE) && (ptr_q < total_q);

  // field table: size in the high byte, base type in the low byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[{wtype_i, wfield_i[FI_W-1:0]}] <= wdata_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[{type_q, ptr_q[FI_W-1:0]}];
    end
  end

  // scan sequencer: each entry is read in SC_ISSUE and checked in SC_WAIT
  always_comb begin
    st_d    = st_q;
    ptr_d   = ptr_q;
    total_d = total_q;
    type_d  = type_q;
    last_d  = last_q;
    ent_d   = ent_q;
    if (start_i) begin
      st_d    = SC_ISSUE;
      ptr_d   = from_i;
      total_d = total_i;
      type_d  = type_i;
    end else begin
      unique case (st_q)
        SC_ISSUE: begin
          if (ptr_q >= total_q) begin
            st_d   = SC_DONE;
            last_d = 1'b1;
            ent_d  = '0;
          end else begin
            st_d = SC_WAIT;
          end
        end
        SC_WAIT: begin
          if (rdata_q[15:8] != 8'h00) begin
            st_d   = SC_DONE;
            last_d = 1'b0;
            ent_d  = rdata_q;
          end else begin
            st_d  = SC_ISSUE;
            ptr_d = ptr_q + 1'b1;
          end
        end
        default: st_d = st_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SC_IDLE;
      ptr_q   <= '0;
      total_q <= '0;
      type_q  <= '0;
      last_q  <= 1'b0;
      ent_q   <= '0;
    end else begin
      st_q    <= st_d;
      ptr_q   <= ptr_d;
      total_q <= total_d;
      type_q  <= type_d;
      last_q  <= last_d;
      ent_q   <= ent_d;
    end
  end

  assign rsp_o.done = (st_q == SC_DONE);
  assign rsp_o.last = last_q;
  assign idx_o      = ptr_q;
  assign entry_o    = ent_q;
endmodule

/* src/dfr_parser.sv */
// Record parser of the deframer: header check, record split, definitions, file crc.
// Depends on dfr_pkg; drives the field table scanner and the result queue.
module dfr_parser #(
  parameter int MAX_FIELDS = dfr_pkg::MAX_FIELDS_DEF,
  parameter int HEADER_LEN = dfr_pkg::HEADER_LEN_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dfr_pkg::item_t                         in_item_i,
  input  logic                                   in_valid_i,
  output logic                                   in_pop_o,
  input  logic                                   out_full_i,
  output logic                                   out_push_o,
  output dfr_pkg::result_t                       out_item_o,
  output logic                                   sc_start_o,
  output logic [$clog2(MAX_FIELDS+1)-1:0]        sc_from_o,
  output logic [dfr_pkg::TYPE_W-1:0]             sc_type_o,
  output logic [$clog2(MAX_FIELDS+1)-1:0]        sc_total_o,
  input  dfr_pkg::scan_rsp_t                     sc_rsp_i,
  input  logic [$clog2(MAX_FIELDS+1)-1:0]        sc_idx_i,
  input  logic [15:0]                            sc_entry_i,
  output logic                                   tw_we_o,
  output logic [dfr_pkg::TYPE_W-1:0]             tw_type_o,
  output logic [$clog2(MAX_FIELDS+1)-1:0]        tw_field_o,
  output logic [15:0]                            tw_data_o
);
  import dfr_pkg::*;

  localparam int FIDX_W = $clog2(MAX_FIELDS + 1);
  localparam int CW     = 10;

  // state
  phase_e            phase_q, phase_d, phase_c;
  logic [3:0]        pos_q, pos_d, pos_c;
  logic              sig_ok_q, sig_ok_d;
  logic [7:0]        hcrc_lo_q, hcrc_lo_d;
  logic [31:0]       dbl_q, dbl_d, dbl_c, dbl_a;
  logic [15:0]       crc_q, crc_d, crc_c;
  logic [7:0]        hdr_q, hdr_d, hdr_c;
  logic [FIDX_W-1:0] cf_q, cf_d, cf_c;
  logic [7:0]        fbl_q, fbl_d, fbl_c, fbl_n;
  logic [7:0]        base_q, base_d;
  logic [LOCAL_TYPES-1:0] def_q, def_d, def_c;
  logic              hs_q, hs_d, hs_c;
  logic [7:0]        normal_q [LOCAL_TYPES];
  logic [7:0]        dev_q [LOCAL_TYPES];

  // per-byte control
  logic              fs;
  logic [7:0]        b;
  logic [TYPE_W-1:0] t_sel;
  logic [7:0]        nfc, dfc;
  logic [CW-1:0]     tot;
  logic              crc_ph, wait_s, hs_req, fld_start, nwe, dwe, twe, commit;
  logic [15:0]       hc;
  phase_e            er_phase;
  result_t           res;

  assign fs     = in_item_i.file_start;
  assign b      = in_item_i.data_byte;
  assign commit = in_valid_i & ~out_full_i & ~wait_s;

  // state as seen by this byte, after a possible file restart
  always_comb begin
    phase_c = fs ? PH_HDR : phase_q;
    pos_c   = fs ? '0 : pos_q;
    dbl_c   = fs ? '0 : dbl_q;
    crc_c   = fs ? '0 : crc_q;
    hdr_c   = fs ? '0 : hdr_q;
    cf_c    = fs ? '0 : cf_q;
    fbl_c   = fs ? '0 : fbl_q;
    def_c   = fs ? '0 : def_q;
    hs_c    = fs ? 1'b0 : hs_q;
  end

  // current local type and its field counts
  assign t_sel  = (phase_c == PH_REC) ? rec_type(b) : rec_type(hdr_c);
  assign nfc    = normal_q[t_sel];
  assign dfc    = dev_q[t_sel];
  assign tot    = CW'(nfc) + CW'(dfc);
  assign crc_ph = (phase_c == PH_REC) || (phase_c == PH_DEFFIX) || (phase_c == PH_FIELD) ||
                  (phase_c == PH_DEVCNT) || (phase_c == PH_DEVDEF) || (phase_c == PH_DATA);
  assign dbl_a  = (crc_ph && dbl_c != '0) ? dbl_c - 32'd1 : dbl_c;
  assign er_phase = (dbl_a != '0) ? PH_REC : PH_CRC;
  assign fbl_n  = (fbl_c != 8'h00) ? fbl_c - 8'd1 : 8'h00;
  assign hc     = {b, hcrc_lo_q};

  // byte decode and next state
  always_comb begin
    phase_d   = phase_c;
    pos_d     = pos_c;
    sig_ok_d  = sig_ok_q;
    hcrc_lo_d = hcrc_lo_q;
    dbl_d     = dbl_a;
    crc_d     = crc_ph ? crc16_step(crc_c, b) : crc_c;
    hdr_d     = hdr_c;
    cf_d      = cf_c;
    fbl_d     = fbl_c;
    base_d    = base_q;
    def_d     = def_c;
    wait_s    = 1'b0;
    hs_req    = 1'b0;
    fld_start = 1'b0;
    nwe       = 1'b0;
    dwe       = 1'b0;
    twe       = 1'b0;
    tw_data_o = '0;
    res       = '0;
    res.byte_class = CLS_IGNORED;

    unique case (phase_c)
      PH_HDR: begin
        res.byte_class = CLS_HDR;
        pos_d = pos_c + 4'd1;
        if (pos_c < 4'd12) crc_d = crc16_step(crc_c, b);
        if (pos_c >= 4'd4 && pos_c < 4'd8) dbl_d[8*pos_c[1:0] +: 8] = b;
        if (pos_c == 4'd12) hcrc_lo_d = b;
        sig_ok_d = ((pos_c == 4'd0) ? 1'b1 : sig_ok_q) &
                   ((pos_c >= 4'd8 && pos_c < 4'd12) ? (b == sig_byte(pos_c[1:0])) : 1'b1);
        if (pos_c == 4'(HEADER_LEN - 1)) begin
          if (!sig_ok_d) begin
            phase_d = PH_ERR_SIG;
          end else if (HEADER_LEN >= 14 && hc != 16'h0000 && hc != crc_d) begin
            phase_d = PH_ERR_HCRC;
          end else begin
            crc_d   = '0;
            phase_d = (dbl_d != '0) ? PH_REC : PH_CRC;
            pos_d   = '0;
          end
        end
      end
      PH_REC: begin
        res.byte_class = CLS_REC_HDR;
        res.local_type = t_sel;
        hdr_d = b;
        if (b[7] || !b[6]) begin
          res.compressed_time = b[7];
          res.time_offset     = b[7] ? b[4:0] : 5'd0;
          if (!def_c[t_sel]) begin
            phase_d = PH_ERR_UNDEF;
          end else if (!(hs_c && sc_rsp_i.done)) begin
            wait_s = 1'b1;
            hs_req = ~hs_c;
          end else if (sc_rsp_i.last) begin
            res.record_last = 1'b1;
            phase_d = er_phase;
            pos_d   = '0;
          end else begin
            cf_d      = sc_idx_i;
            fbl_d     = sc_entry_i[15:8];
            base_d    = sc_entry_i[7:0];
            phase_d   = PH_DATA;
            fld_start = 1'b1;
          end
        end else begin
          def_d[t_sel] = 1'b0;
          pos_d   = '0;
          phase_d = PH_DEFFIX;
        end
      end
      PH_DEFFIX: begin
        res.byte_class = CLS_DEF_FIXED;
        res.local_type = t_sel;
        pos_d = pos_c + 4'd1;
        if (pos_c >= 4'd4) begin
          if (CW'(b) > CW'(MAX_FIELDS)) begin
            phase_d = PH_ERR_MANY;
          end else begin
            nwe   = 1'b1;
            cf_d  = '0;
            pos_d = '0;
            if (b != 8'h00) begin
              phase_d = PH_FIELD;
            end else if (hdr_c[5]) begin
              phase_d = PH_DEVCNT;
            end else begin
              res.record_last = 1'b1;
              def_d[t_sel] = 1'b1;
              phase_d = er_phase;
            end
          end
        end
      end
      PH_FIELD, PH_DEVDEF: begin
        res.byte_class  = (phase_c == PH_FIELD) ? CLS_FIELD_DEF : CLS_DEV_DEF;
        res.local_type  = t_sel;
        res.field_index = 7'(cf_c);
        if (pos_c == 4'd1) fbl_d = b;
        if (pos_c < 4'd2) begin
          pos_d = pos_c + 4'd1;
        end else begin
          res.field_last = 1'b1;
          pos_d     = '0;
          twe       = 1'b1;
          tw_data_o = (phase_c == PH_FIELD) ? {fbl_c, b} : {fbl_c, 8'h00};
          cf_d      = cf_c + 1'b1;
          if (phase_c == PH_FIELD && (CW'(cf_c) + CW'(1)) >= CW'(nfc)) begin
            if (hdr_c[5]) begin
              phase_d = PH_DEVCNT;
            end else begin
              res.record_last = 1'b1;
              def_d[t_sel] = 1'b1;
              phase_d = er_phase;
              pos_d   = '0;
            end
          end else if (phase_c == PH_DEVDEF && (CW'(cf_c) + CW'(1)) >= tot) begin
            res.record_last = 1'b1;
            def_d[t_sel] = 1'b1;
            phase_d = er_phase;
            pos_d   = '0;
          end
        end
      end
      PH_DEVCNT: begin
        res.byte_class = CLS_DEV_COUNT;
        res.local_type = t_sel;
        if (CW'(nfc) + CW'(b) > CW'(MAX_FIELDS)) begin
          phase_d = PH_ERR_MANY;
        end else begin
          dwe   = 1'b1;
          cf_d  = FIDX_W'(nfc);
          pos_d = '0;
          if (b == 8'h00) begin
            res.record_last = 1'b1;
            def_d[t_sel] = 1'b1;
            phase_d = er_phase;
          end else begin
            phase_d = PH_DEVDEF;
          end
        end
      end
      PH_DATA: begin
        res.local_type      = t_sel;
        res.field_index     = 7'(cf_c);
        res.compressed_time = hdr_c[7];
        res.time_offset     = hdr_c[7] ? hdr_c[4:0] : 5'd0;
        if (CW'(cf_c) < CW'(nfc)) begin
          res.byte_class      = CLS_DATA;
          res.field_base_type = base_q;
        end else begin
          res.byte_class = CLS_DEV_DATA;
        end
        fbl_d = fbl_n;
        if (fbl_n == 8'h00) begin
          if (!sc_rsp_i.done) begin
            wait_s = 1'b1;
          end else begin
            res.field_last = 1'b1;
            if (sc_rsp_i.last) begin
              res.record_last = 1'b1;
              phase_d = er_phase;
              pos_d   = '0;
            end else begin
              cf_d      = sc_idx_i;
              fbl_d     = sc_entry_i[15:8];
              base_d    = sc_entry_i[7:0];
              fld_start = 1'b1;
            end
          end
        end
      end
      PH_CRC: begin
        res.byte_class = CLS_CRC;
        if (pos_c == 4'd0) begin
          hdr_d = b;
          pos_d = 4'd1;
        end else begin
          phase_d = ({b, hdr_c} == crc_c) ? PH_PASSED : PH_ERR_CRC;
        end
      end
      default: res.byte_class = CLS_IGNORED;
    endcase

    // status follows the phase after this byte
    unique case (phase_d)
      PH_ERR_SIG:   res.status = ST_BAD_SIG;
      PH_ERR_HCRC:  res.status = ST_HDR_CRC;
      PH_ERR_UNDEF: res.status = ST_UNDEF;
      PH_ERR_MANY:  res.status = ST_TOO_MANY;
      PH_ERR_CRC:   res.status = ST_FILE_CRC;
      PH_PASSED:    res.status = ST_PASSED;
      default:      res.status = ST_RUNNING;
    endcase
  end

  // one scan per defined data record header, while the byte waits at the queue head
  assign hs_d = commit ? 1'b0 : ((in_valid_i & hs_req) ? 1'b1 : hs_q);

  // scanner and table write requests
  assign sc_start_o = (in_valid_i & hs_req) | (commit & fld_start);
  assign sc_from_o  = fld_start ? FIDX_W'(sc_idx_i + 1'b1) : '0;
  assign sc_type_o  = t_sel;
  assign sc_total_o = FIDX_W'(tot);
  assign tw_we_o    = commit & twe;
  assign tw_type_o  = t_sel;
  assign tw_field_o = cf_c;

  assign in_pop_o   = commit;
  assign out_push_o = commit;
  assign out_item_o = res;

  // per-type field counts
  always_ff @(posedge clk_i) begin
    if (commit && nwe) begin
      normal_q[t_sel] <= b;
      dev_q[t_sel]    <= 8'h00;
    end
    if (commit && dwe) begin
      dev_q[t_sel] <= b;
    end
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      pos_q     <= '0;
      sig_ok_q  <= 1'b1;
      hcrc_lo_q <= '0;
      dbl_q     <= '0;
      crc_q     <= '0;
      hdr_q     <= '0;
      cf_q      <= '0;
      fbl_q     <= '0;
      base_q    <= '0;
      def_q     <= '0;
      hs_q      <= 1'b0;
    end else begin
      hs_q <= hs_d;
      if (commit) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        sig_ok_q  <= sig_ok_d;
        hcrc_lo_q <= hcrc_lo_d;
        dbl_q     <= dbl_d;
        crc_q     <= crc_d;
        hdr_q     <= hdr_d;
        cf_q      <= cf_d;
        fbl_q     <= fbl_d;
        base_q    <= base_d;
        def_q     <= def_d;
      end
    end
  end
endmodule

/* bench/typed_record_stream_deframer_unit_tb.sv */
// Self-checking bench for typed_record_stream_deframer_unit: generates record files, both
// well formed and broken, and checks every tagged byte against an in-bench deframer model.
// Depends on dfr_pkg and the deframer RTL.
module typed_record_stream_deframer_unit_tb;
  import dfr_pkg::*;

  localparam int NUM_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int FIELD_LIMIT = 128;
  localparam int TAIL_CYCLES = 60;

  // one tagged byte as seen on the result ports
  typedef struct packed {
    class_e     cls;
    logic [3:0] lt;
    logic [6:0] fidx;
    logic [7:0] base;
    logic       flast;
    logic       rlast;
    logic       ct;
    logic [4:0] toff;
    status_e    stat;
  } tag_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       file_start;
  logic       empty;
  logic       pop;
  logic [3:0] byte_class;
  logic [3:0] local_type;
  logic [6:0] field_index;
  logic [7:0] field_base_type;
  logic       field_last;
  logic       record_last;
  logic       compressed_time;
  logic [4:0] time_offset;
  logic [2:0] status;

  typed_record_stream_deframer_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte),
    .file_start_i      (file_start),
    .empty             (empty),
    .pop               (pop),
    .byte_class_o      (byte_class),
    .local_type_o      (local_type),
    .field_index_o     (field_index),
    .field_base_type_o (field_base_type),
    .field_last_o      (field_last),
    .record_last_o     (record_last),
    .compressed_time_o (compressed_time),
    .time_offset_o     (time_offset),
    .status_o          (status)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // deframer model state
  // ---------------------------------------------------------------------------
  phase_e      ph;
  logic [15:0] spos;
  logic [7:0]  hdr_buf [14];
  logic [31:0] bytes_left;
  logic [15:0] sect_crc;
  logic [7:0]  cur_hdr;
  logic [15:0] cur_fld;
  logic [7:0]  fld_left;
  logic [7:0]  dev_cnt;
  logic        type_ok [16];
  logic [7:0]  norm_cnt [16];
  logic [7:0]  devf_cnt [16];
  logic [15:0] fld_tab [16*FIELD_LIMIT];

  tag_t   tags_due[$];
  item_t  pend[$];
  int     mism;
  int     cyc;

  // reflected crc-16, poly 0xA001, one byte
  function automatic logic [15:0] crc_a001(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    repeat (8) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    return x;
  endfunction

  function automatic int hdr_type(input logic [7:0] h);
    return h[7] ? int'(h[6:5]) : int'(h[3:0]);
  endfunction

  function void clear_model();
    ph = PH_HDR;
    spos = '0;
    bytes_left = '0;
    sect_crc = '0;
    cur_hdr = '0;
    cur_fld = '0;
    fld_left = '0;
    dev_cnt = '0;
    for (int i = 0; i < 14; i++) hdr_buf[i] = '0;
    for (int i = 0; i < 16; i++) begin
      type_ok[i] = 1'b0;
      norm_cnt[i] = '0;
      devf_cnt[i] = '0;
    end
  endfunction

  function logic [15:0] tab_rd(input int t, input int f);
    if (f < FIELD_LIMIT) return fld_tab[t*FIELD_LIMIT + f];
    return '0;
  endfunction

  function int fld_total(input int t);
    return int'(norm_cnt[t]) + int'(devf_cnt[t]);
  endfunction

  // first field at or after from with a nonzero size
  function int first_sized(input int t, input int from);
    int n;
    n = fld_total(t);
    for (int f = from; f < n; f++)
      if ((tab_rd(t, f) >> 8) != 0) return f;
    return n;
  endfunction

  function void close_record();
    ph = (bytes_left != 0) ? PH_REC : PH_CRC;
    spos = '0;
  endfunction

  function void close_def(input int t);
    type_ok[t] = 1'b1;
    close_record();
  endfunction

  // tag one accepted byte and advance the model
  function tag_t tag_byte(input logic [7:0] b, input logic st);
    tag_t r;
    int t;
    int pos;
    int f;
    logic [15:0] hc;
    logic [15:0] ent;
    r = '0;
    r.cls = CLS_IGNORED;
    r.stat = ST_RUNNING;
    if (st) clear_model();
    if (ph inside {PH_REC, PH_DEFFIX, PH_FIELD, PH_DEVCNT, PH_DEVDEF, PH_DATA}) begin
      sect_crc = crc_a001(sect_crc, b);
      if (bytes_left != 0) bytes_left--;
    end
    case (ph)
      PH_HDR: begin
        r.cls = CLS_HDR;
        pos = int'(spos);
        if (pos < 14) hdr_buf[pos] = b;
        if (pos < 12) sect_crc = crc_a001(sect_crc, b);
        if (pos >= 4 && pos < 8) bytes_left |= 32'(b) << (8 * (pos - 4));
        spos++;
        if (pos >= 13) begin
          hc = {hdr_buf[13], hdr_buf[12]};
          if ({hdr_buf[8], hdr_buf[9], hdr_buf[10], hdr_buf[11]} != 32'h2E464954)
            ph = PH_ERR_SIG;
          else if (hc != 0 && hc != sect_crc)
            ph = PH_ERR_HCRC;
          else begin
            sect_crc = '0;
            close_record();
          end
        end
      end
      PH_REC: begin
        r.cls = CLS_REC_HDR;
        cur_hdr = b;
        t = hdr_type(b);
        r.lt = t[3:0];
        if (b[7] || !b[6]) begin
          if (b[7]) begin
            r.ct = 1'b1;
            r.toff = b[4:0];
          end
          if (!type_ok[t]) ph = PH_ERR_UNDEF;
          else begin
            f = first_sized(t, 0);
            if (f >= fld_total(t)) begin
              r.rlast = 1'b1;
              close_record();
            end else begin
              cur_fld = 16'(f);
              ent = tab_rd(t, f);
              fld_left = ent[15:8];
              ph = PH_DATA;
            end
          end
        end else begin
          type_ok[t] = 1'b0;
          spos = '0;
          ph = PH_DEFFIX;
        end
      end
      PH_DEFFIX: begin
        r.cls = CLS_DEF_FIXED;
        t = hdr_type(cur_hdr);
        r.lt = t[3:0];
        pos = int'(spos);
        spos++;
        if (pos >= 4) begin
          if (b > FIELD_LIMIT) ph = PH_ERR_MANY;
          else begin
            norm_cnt[t] = b;
            devf_cnt[t] = '0;
            cur_fld = '0;
            spos = '0;
            if (b > 0) ph = PH_FIELD;
            else if (cur_hdr[5]) ph = PH_DEVCNT;
            else begin
              r.rlast = 1'b1;
              close_def(t);
            end
          end
        end
      end
      PH_FIELD, PH_DEVDEF: begin
        r.cls = (ph == PH_FIELD) ? CLS_FIELD_DEF : CLS_DEV_DEF;
        t = hdr_type(cur_hdr);
        r.lt = t[3:0];
        r.fidx = cur_fld[6:0];
        pos = int'(spos);
        if (pos == 1) fld_left = b;
        if (pos < 2) spos++;
        else begin
          r.flast = 1'b1;
          spos = '0;
          if (cur_fld < FIELD_LIMIT)
            fld_tab[t*FIELD_LIMIT + cur_fld] = {fld_left, (ph == PH_FIELD) ? b : 8'h00};
          cur_fld++;
          if (ph == PH_FIELD && cur_fld >= norm_cnt[t]) begin
            if (cur_hdr[5]) ph = PH_DEVCNT;
            else begin
              r.rlast = 1'b1;
              close_def(t);
            end
          end else if (ph == PH_DEVDEF && int'(cur_fld) >= fld_total(t)) begin
            r.rlast = 1'b1;
            close_def(t);
          end
        end
      end
      PH_DEVCNT: begin
        r.cls = CLS_DEV_COUNT;
        t = hdr_type(cur_hdr);
        r.lt = t[3:0];
        if (int'(norm_cnt[t]) + int'(b) > FIELD_LIMIT) ph = PH_ERR_MANY;
        else begin
          devf_cnt[t] = b;
          dev_cnt = b;
          cur_fld = 16'(norm_cnt[t]);
          spos = '0;
          if (b == 0) begin
            r.rlast = 1'b1;
            close_def(t);
          end else ph = PH_DEVDEF;
        end
      end
      PH_DATA: begin
        t = hdr_type(cur_hdr);
        r.lt = t[3:0];
        r.fidx = cur_fld[6:0];
        if (cur_hdr[7]) begin
          r.ct = 1'b1;
          r.toff = cur_hdr[4:0];
        end
        if (cur_fld < norm_cnt[t]) begin
          r.cls = CLS_DATA;
          ent = tab_rd(t, int'(cur_fld));
          r.base = ent[7:0];
        end else r.cls = CLS_DEV_DATA;
        if (fld_left != 0) fld_left--;
        if (fld_left == 0) begin
          f = first_sized(t, int'(cur_fld) + 1);
          r.flast = 1'b1;
          if (f >= fld_total(t)) begin
            r.rlast = 1'b1;
            close_record();
          end else begin
            cur_fld = 16'(f);
            ent = tab_rd(t, f);
            fld_left = ent[15:8];
          end
        end
      end
      PH_CRC: begin
        r.cls = CLS_CRC;
        if (spos == 0) begin
          cur_hdr = b;
          spos = 16'd1;
        end else
          ph = ({b, cur_hdr} == sect_crc) ? PH_PASSED : PH_ERR_CRC;
      end
      default: r.cls = CLS_IGNORED;
    endcase
    case (ph)
      PH_ERR_SIG:   r.stat = ST_BAD_SIG;
      PH_ERR_HCRC:  r.stat = ST_HDR_CRC;
      PH_ERR_UNDEF: r.stat = ST_UNDEF;
      PH_ERR_MANY:  r.stat = ST_TOO_MANY;
      PH_ERR_CRC:   r.stat = ST_FILE_CRC;
      PH_PASSED:    r.stat = ST_PASSED;
      default:      r.stat = ST_RUNNING;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // file generator
  // ---------------------------------------------------------------------------
  logic [7:0] sect[$];
  logic       g_def [16];
  int         g_norm [16];
  int         g_dev [16];
  int         g_size [16][FIELD_LIMIT];

  function automatic int pick_size(input bit sparse);
    if (sparse) return ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 3);
    if ($urandom_range(0, 79) == 0) return $urandom_range(5, 255);
    return ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 4);
  endfunction

  // definition record; an oversized count stops the listing there
  task automatic put_def(input int t, input int n, input bit dev, input int d);
    int sz;
    g_def[t] = 1'b0;
    sect.push_back({2'b01, dev, 1'($urandom), 4'(t)});
    repeat (4) sect.push_back(8'($urandom));
    sect.push_back(8'(n));
    if (n > FIELD_LIMIT) return;
    for (int i = 0; i < n; i++) begin
      sz = pick_size(n > 16);
      g_size[t][i] = sz;
      sect.push_back(8'($urandom));
      sect.push_back(8'(sz));
      sect.push_back(8'($urandom));
    end
    if (dev) begin
      sect.push_back(8'(d));
      if (n + d > FIELD_LIMIT) return;
      for (int i = 0; i < d; i++) begin
        sz = pick_size(1'b0);
        g_size[t][n+i] = sz;
        sect.push_back(8'($urandom));
        sect.push_back(8'(sz));
        sect.push_back(8'($urandom));
      end
    end
    g_norm[t] = n;
    g_dev[t] = dev ? d : 0;
    g_def[t] = 1'b1;
  endtask

  task automatic put_data(input int t, input bit comp);
    if (comp) sect.push_back({1'b1, 2'(t), 5'($urandom)});
    else sect.push_back({2'b00, 2'($urandom), 4'(t)});
    if (!g_def[t]) return;
    for (int i = 0; i < g_norm[t] + g_dev[t]; i++)
      repeat (g_size[t][i]) sect.push_back(8'($urandom));
  endtask

  function automatic int defined_type(input bit low_only);
    int c[$];
    for (int i = 0; i < (low_only ? 4 : 16); i++) if (g_def[i]) c.push_back(i);
    if (c.size() == 0) return -1;
    return c[$urandom_range(0, c.size() - 1)];
  endfunction

  // wrap the data section in header and trailer and queue it for the driver
  task automatic emit_file(input int hcrc_mode, input bit bad_sig, input bit bad_crc,
                           input int size_mode);
    logic [7:0]  h[14];
    logic [15:0] c;
    logic [31:0] sz;
    item_t       it;
    int          cut;
    int          n;
    sz = 32'(sect.size());
    if (size_mode == 1) sz = $urandom_range(0, sect.size() + 3);
    if (size_mode == 2) sz = $urandom;
    h[0] = 8'd14;
    h[1] = 8'($urandom);
    h[2] = 8'($urandom);
    h[3] = 8'($urandom);
    {h[7], h[6], h[5], h[4]} = sz;
    {h[8], h[9], h[10], h[11]} = 32'h2E464954;
    if (bad_sig) h[8 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    c = '0;
    for (int i = 0; i < 12; i++) c = crc_a001(c, h[i]);
    if (hcrc_mode == 0) c = '0;
    if (hcrc_mode == 2) c ^= 16'(1 << $urandom_range(0, 15));
    {h[13], h[12]} = c;
    c = '0;
    foreach (sect[i]) c = crc_a001(c, sect[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    for (int i = 0; i < 14; i++) sect.push_front(h[13 - i]);
    sect.push_back(c[7:0]);
    sect.push_back(c[15:8]);
    repeat ($urandom_range(0, 2)) sect.push_back(8'($urandom));
    n = sect.size();
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, n) : n;
    for (int i = 0; i < cut; i++) begin
      it.data_byte = sect[i];
      it.file_start = (i == 0);
      pend.push_back(it);
    end
    sect.delete();
  endtask

  task automatic random_file();
    int mode;
    int nrec;
    int t;
    int n;
    mode = $urandom_range(0, 99);
    for (int i = 0; i < 16; i++) g_def[i] = 1'b0;
    nrec = (mode < 4) ? 0 : $urandom_range(1, 8);
    for (int r = 0; r < nrec; r++) begin
      t = defined_type(1'b0);
      if (t < 0 || $urandom_range(0, 9) < 3) begin
        n = ($urandom_range(0, 29) == 0) ? FIELD_LIMIT : $urandom_range(0, 6);
        put_def((r == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15), n,
                $urandom_range(0, 2) == 0, $urandom_range(0, 3));
      end else if ($urandom_range(0, 9) < 4 && defined_type(1'b1) >= 0)
        put_data(defined_type(1'b1), 1'b1);
      else put_data(t, 1'b0);
    end
    // error endings
    if (mode >= 90 && mode < 94) begin
      n = $urandom_range(0, 6);
      if (mode < 92) put_def($urandom_range(0, 15), $urandom_range(129, 255), 1'b0, 0);
      else put_def($urandom_range(0, 15), n, 1'b1, $urandom_range(129 - n, 255));
    end else if (mode >= 94) begin
      do t = $urandom_range(0, 15); while (g_def[t]);
      put_data(t, t < 4 && $urandom_range(0, 1));
      repeat ($urandom_range(0, 4)) sect.push_back(8'($urandom));
    end
    emit_file($urandom_range(0, 2), mode >= 85 && mode < 88, $urandom_range(0, 9) == 0,
              (mode >= 80 && mode < 85) ? $urandom_range(1, 2) : 0);
  endtask

  // stimulus: two directed files, then random ones
  initial begin
    for (int i = 0; i < 16; i++) g_def[i] = 1'b0;
    // bad signature with a random data size field
    emit_file(0, 1'b1, 1'b0, 2);
    // empty data section, header crc present
    emit_file(1, 1'b0, 1'b0, 0);
    while (pend.size() < NUM_ITEMS) random_file();
    wait (rst_ni);
    while (pend.size() != 0 || push || tags_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mism == 0 && tags_due.size() == 0)
      $display("typed_record_stream_deframer_unit_tb: clean");
    else
      $display("typed_record_stream_deframer_unit_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver, result sink and monitor
  // ---------------------------------------------------------------------------
  bit in_took;
  bit out_took;
  int in_gap;
  int out_gap;
  bit calm;
  int calm_left;

  function automatic int draw_wait();
    return calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
  endfunction

  initial begin
    push = 1'b0;
    pop = 1'b0;
    data_byte = '0;
    file_start = 1'b0;
    mism = 0;
    cyc = 0;
    in_gap = 0;
    out_gap = 0;
    calm = 1'b0;
    calm_left = 200;
    clear_model();
  end

  // input side: hold until accepted, then wait a drawn gap
  always @(negedge clk_i) begin
    if (rst_ni && !(push && !in_took)) begin
      if (in_took) begin
        in_took = 1'b0;
        in_gap = draw_wait();
        if (--calm_left == 0) begin
          calm = ~calm;
          calm_left = $urandom_range(50, 300);
        end
      end
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (pend.size() != 0) begin
        {data_byte, file_start} <= pend.pop_front();
        push <= 1'b1;
      end else push <= 1'b0;
    end
  end

  // result side: stall for a drawn gap after each transaction
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        out_took = 1'b0;
        out_gap = draw_wait();
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    tag_t want;
    tag_t got;
    if (rst_ni) begin
      if (push && !full) begin
        tags_due.push_back(tag_byte(data_byte, file_start));
        in_took = 1'b1;
      end
      if (pop && !empty) begin
        out_took = 1'b1;
        got = {class_e'(byte_class), local_type, field_index, field_base_type, field_last,
               record_last, compressed_time, time_offset, status_e'(status)};
        if (tags_due.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = tags_due.pop_front();
          if (want != got) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: cls %0d/%0d lt %0d/%0d idx %0d/%0d base %h/%h",
                       want.cls, got.cls, want.lt, got.lt, want.fidx, got.fidx,
                       want.base, got.base,
                       "  flast %b/%b rlast %b/%b ct %b/%b toff %0d/%0d st %0d/%0d",
                       want.flast, got.flast, want.rlast, got.rlast, want.ct, got.ct,
                       want.toff, got.toff, want.stat, got.stat);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("typed_record_stream_deframer_unit_tb: errors");
      $finish;
    end
  end

endmodule
